FILE: src/assert_macros.svh
// Assertion macros used by the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, idle in reset.
`define FASM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define FASM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/fasm_pkg.sv
// Types and fixed constants of the finite-automaton string matcher.
package fasm_pkg;

	localparam int SYMBOL_W    = 4;
	localparam int LEN_W       = 5;
	localparam int STATE_W     = 5;
	localparam int POS_W       = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_SYMBOLS = 2'd0,
		REG_PATTERN_LENGTH  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                first;
	} text_t;

	typedef struct packed {
		logic               match;
		logic [POS_W-1:0]   shift;
		logic [STATE_W-1:0] match_state;
	} result_t;

endpackage

FILE: src/fasm_table.sv
// Pattern register and its precomputed prefix-overlap table.
module fasm_table #(
	parameter int PATTERN_MAX = 16,
	parameter int SYMBOL_BITS = 4
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [fasm_pkg::CFG_DATA_W-1:0]           wr_data,
	output logic [PATTERN_MAX*SYMBOL_BITS-1:0]        pattern,
	output logic [PATTERN_MAX-1:0][PATTERN_MAX:0]     overlap
);
	import fasm_pkg::*;

	localparam int PW = PATTERN_MAX * SYMBOL_BITS;

	typedef logic [PATTERN_MAX-1:0][PATTERN_MAX:0] overlap_t;

	// overlap[k-1][q]: k <= q+1 and prefix k-1 equals pattern[q+1-k .. q-1]
	function automatic overlap_t build(input logic [PW-1:0] p);
		overlap_t t;
		int       idx;
		t = '0;
		for (int k = 1; k <= PATTERN_MAX; k++) begin
			for (int q = 0; q <= PATTERN_MAX; q++) begin
				t[k-1][q] = (k <= q + 1);
				for (int j = 0; j < PATTERN_MAX - 1; j++) begin
					idx = (q + 1 - k + j + PATTERN_MAX) % PATTERN_MAX;
					if ((j + 1 < k) && (k <= q + 1) &&
					    (p[j*SYMBOL_BITS +: SYMBOL_BITS] !=
					     p[idx*SYMBOL_BITS +: SYMBOL_BITS])) begin
						t[k-1][q] = 1'b0;
					end
				end
			end
		end
		return t;
	endfunction

	logic [PW-1:0] pattern_q;
	overlap_t      overlap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			overlap_q <= build('0);
		end else if (wr_en) begin
			pattern_q <= wr_data[PW-1:0];
			overlap_q <= build(wr_data[PW-1:0]);
		end
	end

	assign pattern = pattern_q;
	assign overlap = overlap_q;

endmodule

FILE: src/finite_automaton_string_matcher.sv
// Top level of the finite-automaton string matcher.
//
//  channel  | signals                        | direction | transfer when
//  text     | text_valid, text_stall, text   | in        | valid && !stall
//  result   | result_valid, result_stall,    | out       | valid && !stall
//           | result                         |           |
//  cfg      | cfg_valid, cfg_ready,          | in        | valid && ready
//           | cfg_index, cfg_data            |           |
//
// One symbol per cycle unless text_stall; a result passes the input stage, then the output register.
// The next state comes from the overlap table, rebuilt on each pattern write,
// plus one symbol compare per prefix length and a priority pick.
// Reset clears state and position to zero, pattern to zero, length to one.
// A stalled result holds the input stage; text stalls only when both are full.
`include "assert_macros.svh"

module finite_automaton_string_matcher #(
	parameter int PATTERN_MAX = 16,
	parameter int SYMBOL_BITS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              text_valid,
	output logic                              text_stall,
	input  fasm_pkg::text_t                   text,
	output logic                              result_valid,
	input  logic                              result_stall,
	output fasm_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fasm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [fasm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fasm_pkg::*;

	localparam int SW = $clog2(PATTERN_MAX + 1);
	localparam int PW = PATTERN_MAX * SYMBOL_BITS;

	logic [PW-1:0]                     pattern;
	logic [PATTERN_MAX-1:0][PATTERN_MAX:0] overlap;
	logic                              pat_wr;

	logic [LEN_W-1:0] len_q;
	logic [SW-1:0]    state_q;
	logic [POS_W-1:0] position_q;

	logic    valid_s1;
	text_t   text_s1;
	logic    out_valid_q;
	result_t out_q;

	logic                   adv;
	logic [SW-1:0]          eff_len;
	logic [SW-1:0]          cur_state;
	logic [POS_W-1:0]       cur_pos;
	logic [PATTERN_MAX-1:0] fit;
	logic [SW-1:0]          next_state;
	logic                   hit;
	result_t                res_d;

	assign cfg_ready = 1'b1;
	assign pat_wr    = cfg_valid && (cfg_index == REG_PATTERN_SYMBOLS);

	fasm_table #(
		.PATTERN_MAX (PATTERN_MAX),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (pat_wr),
		.wr_data (cfg_data),
		.pattern (pattern),
		.overlap (overlap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_valid && (cfg_index == REG_PATTERN_LENGTH)) begin
			len_q <= cfg_data[LEN_W-1:0];
		end
	end

	assign adv        = valid_s1 && (!out_valid_q || !result_stall);
	assign text_stall = valid_s1 && out_valid_q && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			text_s1 <= text;
		end
	end

	always_comb begin
		if (len_q == '0) begin
			eff_len = SW'(1);
		end else if (len_q > LEN_W'(PATTERN_MAX)) begin
			eff_len = SW'(PATTERN_MAX);
		end else begin
			eff_len = len_q[SW-1:0];
		end
	end

	always_comb begin
		cur_state = text_s1.first ? '0 : state_q;
		if (cur_state > eff_len) begin
			cur_state = eff_len;
		end
		cur_pos = text_s1.first ? '0 : position_q;
	end

	always_comb begin
		next_state = '0;
		for (int k = 1; k <= PATTERN_MAX; k++) begin
			fit[k-1] = overlap[k-1][cur_state] &&
			           (pattern[(k-1)*SYMBOL_BITS +: SYMBOL_BITS] ==
			            text_s1.symbol[SYMBOL_BITS-1:0]) &&
			           (SW'(k) <= eff_len);
			if (fit[k-1]) begin
				next_state = SW'(k);
			end
		end
	end

	always_comb begin
		hit               = (next_state == eff_len);
		res_d.match       = hit;
		res_d.shift       = hit ? (cur_pos - POS_W'(eff_len) + POS_W'(1)) : '0;
		res_d.match_state = STATE_W'(next_state);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			position_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q     <= next_state;
				position_q  <= cur_pos + POS_W'(1);
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`FASM_ASSERT(a_shift_zero, (out_valid_q && !out_q.match) |-> (out_q.shift == '0), "shift set")
	`FASM_ASSERT(a_state_bound, state_q <= SW'(PATTERN_MAX), "state above pattern max")
	`FASM_ASSERT_ALWAYS(a_stall_needs_item, text_stall |-> (valid_s1 && out_valid_q), "stall empty")
	`FASM_ASSERT(a_s1_held, (valid_s1 && !adv) |=> valid_s1, "held item dropped")

endmodule

FILE: bench/finite_automaton_string_matcher_tb.sv
// Self-checking testbench for the finite-automaton string matcher.
module finite_automaton_string_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fasm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct {
		text_t t;
		bit    hold;
	} symbol_job_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   text_valid = 1'b0;
	logic                   text_stall;
	text_t                  text = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_t                result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	symbol_job_t symbol_jobs[$];
	result_t     expected_results[$];

	logic [CFG_DATA_W-1:0] pattern_copy = '0;
	logic [LEN_W-1:0]      length_copy = 5'd1;
	logic [STATE_W-1:0]    prefix_len = '0;
	logic [POS_W-1:0]      text_pos = '0;

	bit symbol_taken = 1'b0;
	bit no_idle = 1'b0;
	int send_wait = 0;
	int recv_wait = 0;
	int errors = 0;
	int cycles = 0;

	finite_automaton_string_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] len);
		if (len == 0)
			return LEN_W'(1);
		if (len > 16)
			return LEN_W'(16);
		return len;
	endfunction

	function automatic logic [SYMBOL_W-1:0] pattern_at(input int i);
		return pattern_copy[(i % 16) * SYMBOL_W +: SYMBOL_W];
	endfunction

	// longest pattern prefix that ends the current prefix followed by sym
	function automatic logic [STATE_W-1:0] longest_prefix(input logic [STATE_W-1:0] q_in,
			input logic [SYMBOL_W-1:0] sym, input logic [LEN_W-1:0] m);
		int q;
		int k;
		bit fits;
		q = (q_in > m) ? m : q_in;
		k = (q + 1 > m) ? m : q + 1;
		while (k > 0) begin
			fits = (pattern_at(k - 1) == sym);
			for (int j = 0; j + 1 < k; j++)
				if (pattern_at(j) != pattern_at(q + 1 - k + j))
					fits = 1'b0;
			if (fits)
				break;
			k--;
		end
		return k[STATE_W-1:0];
	endfunction

	task automatic step_automaton(input text_t t);
		result_t r;
		logic [LEN_W-1:0] m;
		m = effective_length(length_copy);
		if (t.first) begin
			prefix_len = '0;
			text_pos = '0;
		end
		prefix_len = longest_prefix(prefix_len, t.symbol, m);
		r.match = (prefix_len == m);
		r.shift = r.match ? text_pos - POS_W'(m) + 32'd1 : '0;
		r.match_state = prefix_len;
		text_pos = text_pos + 32'd1;
		expected_results.push_back(r);
	endtask

	task automatic queue_symbol(input logic [SYMBOL_W-1:0] sym, input logic restart,
			input bit hold);
		symbol_job_t job;
		job.t.symbol = sym;
		job.t.first = restart;
		job.hold = hold;
		symbol_jobs.push_back(job);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PATTERN_SYMBOLS)
			pattern_copy = data;
		else if (idx == REG_PATTERN_LENGTH)
			length_copy = data[LEN_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (symbol_jobs.size() != 0 || text_valid || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// text driver
	always @(negedge clk) begin : text_driver
		symbol_job_t job;
		if (arst_n && (!text_valid || symbol_taken)) begin
			symbol_taken = 1'b0;
			if (send_wait > 0) begin
				send_wait--;
				text_valid <= 1'b0;
			end else if (symbol_jobs.size() != 0 &&
					!(symbol_jobs[0].hold && expected_results.size() != 0)) begin
				job = symbol_jobs.pop_front();
				text <= job.t;
				text_valid <= 1'b1;
				send_wait = draw_wait();
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		if (result_valid && recv_wait > 0) begin
			recv_wait--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (text_valid && !text_stall) begin
				step_automaton(text);
				symbol_taken = 1'b1;
			end
			if (result_valid && !result_stall) begin
				recv_wait = draw_wait();
				if (expected_results.size() == 0) begin
					$error("result transfer with no symbol outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.match !== want.match) begin
						$error("match: expected %0d, got %0d", want.match, result.match);
						errors++;
					end
					if (result.shift !== want.shift) begin
						$error("shift: expected %0d, got %0d", want.shift, result.shift);
						errors++;
					end
					if (result.match_state !== want.match_state) begin
						$error("match_state: expected %0d, got %0d", want.match_state,
							result.match_state);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL finite_automaton_string_matcher");
			$finish;
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] pat;
		logic [LEN_W-1:0]      len;
		logic [LEN_W-1:0]      m;
		logic [SYMBOL_W-1:0]   sym_a;
		logic [SYMBOL_W-1:0]   sym_b;
		int  count;
		int  n;
		int  kind;
		int  pick;
		bit  hold;
		bit  held;
		bit  restart;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset pattern: zero symbol, length one
		queue_symbol(4'd0, 1'b1, 1'b0);
		queue_symbol(4'd15, 1'b0, 1'b0);
		queue_symbol(4'd0, 1'b0, 1'b0);
		wait_idle();

		// zero length acts as one; writes to unused indexes are dropped
		write_register(REG_PATTERN_SYMBOLS, 64'h5);
		write_register(REG_PATTERN_LENGTH, 64'h0);
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, '1);
		queue_symbol(4'd5, 1'b1, 1'b0);
		queue_symbol(4'd10, 1'b0, 1'b0);
		queue_symbol(4'd5, 1'b0, 1'b0);
		wait_idle();

		// oversize length acts as sixteen; full run plus one overlapping match
		write_register(REG_PATTERN_SYMBOLS, '1);
		write_register(REG_PATTERN_LENGTH, '1);
		for (int i = 0; i < 17; i++)
			queue_symbol(4'd15, i == 0, 1'b0);
		wait_idle();

		// shorter length mid-stream clamps the state
		write_register(REG_PATTERN_LENGTH, 64'd2);
		queue_symbol(4'd15, 1'b0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph == 2 || ph == 5);
			if (ph % 2 == 1) begin
				// two-symbol alphabet gives rich self-overlap
				sym_a = SYMBOL_W'($urandom_range(0, 15));
				sym_b = SYMBOL_W'($urandom_range(0, 15));
				for (int i = 0; i < 16; i++)
					pat[i * SYMBOL_W +: SYMBOL_W] = ($urandom_range(0, 2) == 0) ? sym_b : sym_a;
			end else begin
				pat = {$urandom, $urandom};
			end
			case (ph)
				0: len = 5'd16;
				1: len = 5'd1;
				3: len = 5'd0;
				6: len = LEN_W'($urandom_range(17, 31));
				default: len = LEN_W'($urandom_range(2, 15));
			endcase
			write_register(REG_PATTERN_SYMBOLS, pat);
			write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
			m = effective_length(len);
			count = 0;
			held = 1'b0;
			while (count < 50) begin
				hold = !held && count >= 20;
				held |= hold;
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, m) : m;
					restart = ($urandom_range(0, 9) == 0);
					for (int i = 0; i < n; i++)
						queue_symbol(pat[i * SYMBOL_W +: SYMBOL_W], restart && i == 0,
							hold && i == 0);
					count += n;
				end else if (kind < 9) begin
					pick = $urandom_range(0, m - 1);
					queue_symbol(pat[pick * SYMBOL_W +: SYMBOL_W], 1'b0, hold);
					count++;
				end else begin
					queue_symbol(SYMBOL_W'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
						hold);
					count++;
				end
			end
			wait_idle();
		end

		if (errors == 0 && expected_results.size() == 0)
			$display("PASS finite_automaton_string_matcher");
		else
			$display("FAIL finite_automaton_string_matcher");
		$finish;
	end

endmodule
